// File: design/rvd_pkg.sv
// ----------------------------------------------------------------------------
// rvd_pkg
// Shared constants, stage map and sine table for the ripple vertex displacer.
// ----------------------------------------------------------------------------
package rvd_pkg;

	// Quarter-wave sine table size and its address width (DEPTH + 1 entries)
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH + 1);

	localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
	// 0.1 / (2*pi*16) in Q0.32
	localparam logic [22:0] PHASE_K = 23'd4272283;

	// Configuration register indexes
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 17;
	localparam logic [CFG_AW-1:0] CFG_CENTER_X  = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_CENTER_Y  = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_RADIUS    = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_WAVES     = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_AMPLITUDE = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_PROGRESS  = 3'd5;

	// Stage map: one root bit and one quotient bit per stage
	localparam int SQRT_STEPS = 17;
	localparam int DIV_STEPS  = 17;
	localparam int STG_SQ0    = 4;
	localparam int STG_SQL    = STG_SQ0 + SQRT_STEPS - 1;
	localparam int STG_R      = STG_SQL + 1;
	localparam int STG_DV0    = STG_R + 1;
	localparam int STG_DVL    = STG_DV0 + DIV_STEPS - 1;
	localparam int STG_RATE   = STG_DVL + 1;
	localparam int STG_ADDR   = STG_RATE + 1;
	localparam int STG_ROM    = STG_ADDR + 1;
	localparam int STG_SA     = STG_ROM + 1;
	localparam int STG_P      = STG_SA + 1;
	localparam int STG_DISP   = STG_P + 1;
	localparam int STG_OUT    = STG_DISP + 1;

	typedef logic [14:0] sine_rom_t [0:SINE_TABLE_DEPTH];

	// Shift-and-subtract quotient for the table build
	function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = 0;
		rem = 0;
		for (int b = 63; b >= 0; b--) begin
			rem = (rem << 1) | ((num >> b) & 64'd1);
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | (64'd1 << b);
			end
		end
		return quo;
	endfunction

	// Build round(32767*sin(pi/2*i/DEPTH)) with a Q30 Taylor series
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		longint unsigned x;
		longint unsigned t;
		longint sum;
		longint e;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x = (HALFPI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
			t = x;
			sum = longint'(x);
			for (int k = 1; k <= 8; k++) begin
				t = (t * x) >> 30;
				t = (t * x) >> 30;
				t = udiv64(t, longint'((2 * k) * (2 * k + 1)));
				if (k % 2 == 1) begin
					sum = sum - longint'(t);
				end else begin
					sum = sum + longint'(t);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			e = longint'((longint'(sum) * 32767 + (64'sd1 <<< 29)) >>> 30);
			if (e > 32767) begin
				e = 32767;
			end
			rom[i] = e[14:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: design/ripple_vertex_displace.sv
// ----------------------------------------------------------------------------
// ripple_vertex_displace
// Radial ripple on grid vertices: distance to the centre, falloff rate and a
// sine wave displace z inside the disc; z passes through outside it.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  in       request    in_valid/in_ready    vert_x, vert_y, vert_z
//  out      result     out_valid/out_ready  new_z, inside_disc
//  cfg      write      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One vertex enters per cycle while the output is not stalled; the pipeline holds a
// 17-stage square root and a 17-stage divider (one bit per stage each).
// Reset clears all valid bits and loads the register defaults.
// A stall at the output freezes the whole pipeline; in_ready follows it.
// Configuration writes are always taken.
//
module ripple_vertex_displace (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [15:0]            vert_x,
	input  logic signed [15:0]            vert_y,
	input  logic signed [15:0]            vert_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [15:0]            new_z,
	output logic                          inside_disc,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rvd_pkg::CFG_AW-1:0]    cfg_index,
	input  logic [rvd_pkg::CFG_DW-1:0]    cfg_data
);
	import rvd_pkg::*;

	localparam logic [SINE_AW+13:0] DEPTH_W = (SINE_AW+14)'(SINE_TABLE_DEPTH);
	localparam logic [SINE_AW-1:0]  DEPTH_A = SINE_AW'(SINE_TABLE_DEPTH);

	// Configuration registers
	logic signed [15:0] center_x_q, center_y_q, amplitude_q;
	logic [14:0]        radius_q;
	logic [7:0]         waves_q;
	logic [16:0]        progress_q;

	logic en;

	// Pipeline registers
	logic [1:STG_OUT]         vld_s;
	logic signed [15:0]       vz_s [1:STG_DISP];
	logic signed [16:0]       dx_s1, dy_s1;
	logic [32:0]              dx2_s2, dy2_s2;
	logic [33:0]              d2_s3;
	logic [33:0]              sqt_val_s  [STG_SQ0:STG_SQL];
	logic [18:0]              sqt_rem_s  [STG_SQ0:STG_SQL];
	logic [16:0]              sqt_root_s [STG_SQ0:STG_SQL];
	logic                     inside_s   [STG_R:STG_DISP];
	logic [14:0]              r_s21;
	logic [14:0]              div_rem_s  [STG_DV0:STG_DVL];
	logic [16:0]              div_q_s    [STG_DV0:STG_DVL];
	logic [15:0]              phase_s    [STG_DV0:STG_RATE];
	logic [16:0]              rate_s     [STG_RATE:STG_SA];
	logic [SINE_AW-1:0]       addr_s40;
	logic                     neg_s      [STG_ADDR:STG_ROM];
	logic [14:0]              mag_s41;
	logic signed [31:0]       sa_s42;
	logic signed [49:0]       p_s43;
	logic signed [14:0]       disp_s44;
	logic signed [15:0]       new_z_s45;
	logic                     inside_s45;

	// Advance everything unless the output holds a result that is not taken
	assign en        = ~vld_s[STG_OUT] | out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_s[STG_OUT];
	assign new_z       = new_z_s45;
	assign inside_disc = inside_s45;

	// Register writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= '0;
			center_y_q  <= '0;
			radius_q    <= 15'd160;
			waves_q     <= 8'd1;
			amplitude_q <= 16'sd768;
			progress_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CENTER_X:  center_x_q  <= cfg_data[15:0];
				CFG_CENTER_Y:  center_y_q  <= cfg_data[15:0];
				CFG_RADIUS:    radius_q    <= cfg_data[14:0];
				CFG_WAVES:     waves_q     <= cfg_data[7:0];
				CFG_AMPLITUDE: amplitude_q <= cfg_data[15:0];
				CFG_PROGRESS:  progress_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Shift valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int n = 2; n <= STG_OUT; n++) begin
				vld_s[n] <= vld_s[n-1];
			end
		end
	end

	// Carry the original z down the pipe
	always_ff @(posedge clk) begin
		if (en) begin
			vz_s[1] <= vert_z;
			for (int n = 2; n <= STG_DISP; n++) begin
				vz_s[n] <= vz_s[n-1];
			end
		end
	end

	// Offsets, squares, squared distance
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= 17'(center_x_q) - 17'(vert_x);
			dy_s1  <= 17'(center_y_q) - 17'(vert_y);
			dx2_s2 <= 33'(unsigned'(34'(dx_s1 * dx_s1)));
			dy2_s2 <= 33'(unsigned'(34'(dy_s1 * dy_s1)));
			d2_s3  <= 34'(dx2_s2) + 34'(dy2_s2);
		end
	end

	// Square root: one root bit per stage from two radicand bits
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [20:0] rem_in;
		logic [20:0] trial;
		logic [16:0] root_in;
		logic [33:0] val_in;

		if (k == 0) begin : g_first
			assign val_in  = d2_s3;
			assign rem_in  = {19'd0, d2_s3[33:32]};
			assign root_in = '0;
		end else begin : g_next
			assign val_in  = sqt_val_s[STG_SQ0+k-1];
			assign rem_in  = {sqt_rem_s[STG_SQ0+k-1],
				sqt_val_s[STG_SQ0+k-1][33-2*k -: 2]};
			assign root_in = sqt_root_s[STG_SQ0+k-1];
		end
		assign trial = {2'b00, root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				sqt_val_s[STG_SQ0+k] <= val_in;
				if (rem_in >= trial) begin
					sqt_rem_s[STG_SQ0+k]  <= 19'(rem_in - trial);
					sqt_root_s[STG_SQ0+k] <= {root_in[15:0], 1'b1};
				end else begin
					sqt_rem_s[STG_SQ0+k]  <= rem_in[18:0];
					sqt_root_s[STG_SQ0+k] <= {root_in[15:0], 1'b0};
				end
			end
		end
	end

	// Disc test and distance from the rim
	always_ff @(posedge clk) begin
		if (en) begin
			inside_s[STG_R] <= (radius_q != '0) &&
				(sqt_root_s[STG_SQL] < {2'b00, radius_q});
			r_s21 <= radius_q - sqt_root_s[STG_SQL][14:0];
		end
	end

	// Falloff divide r*65536/radius: one quotient bit per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [15:0] rem_in;
		logic [15:0] q_in;
		logic        bit_q;

		if (k == 0) begin : g_first
			assign rem_in = {1'b0, r_s21};
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = {div_rem_s[STG_DV0+k-1], 1'b0};
			assign q_in   = div_q_s[STG_DV0+k-1][15:0];
		end
		assign bit_q = rem_in >= {1'b0, radius_q};

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[STG_DV0+k] <= bit_q ? 15'(rem_in - {1'b0, radius_q})
					: rem_in[14:0];
				div_q_s[STG_DV0+k]   <= {q_in, bit_q};
			end
		end
	end

	// Phase at the first divide stage, then carry it and the disc flag along
	always_ff @(posedge clk) begin
		logic [37:0] rk;
		logic [24:0] pw;
		rk = 38'(r_s21) * 38'(PHASE_K);
		pw = 25'(progress_q) * 25'(waves_q);
		if (en) begin
			phase_s[STG_DV0] <= pw[15:0] + rk[31:16];
			for (int n = STG_DV0 + 1; n <= STG_RATE; n++) begin
				phase_s[n] <= phase_s[n-1];
			end
			for (int n = STG_R + 1; n <= STG_DISP; n++) begin
				inside_s[n] <= inside_s[n-1];
			end
		end
	end

	// Rate, ROM address, ROM read
	always_ff @(posedge clk) begin
		logic [33:0]         qq;
		logic [SINE_AW+13:0] idx_prod;
		logic [SINE_AW-1:0]  idx;
		qq       = 34'(div_q_s[STG_DVL]) * 34'(div_q_s[STG_DVL]);
		idx_prod = (SINE_AW+14)'(phase_s[STG_RATE][13:0]) * DEPTH_W;
		idx      = idx_prod[SINE_AW+13:14];
		if (en) begin
			rate_s[STG_RATE]   <= qq[32:16];
			rate_s[STG_ADDR]   <= rate_s[STG_RATE];
			rate_s[STG_ROM]    <= rate_s[STG_ADDR];
			rate_s[STG_SA]     <= rate_s[STG_ROM];
			addr_s40           <= phase_s[STG_RATE][14] ? DEPTH_A - idx : idx;
			neg_s[STG_ADDR]    <= phase_s[STG_RATE][15];
			neg_s[STG_ROM]     <= neg_s[STG_ADDR];
			mag_s41            <= SINE_ROM[addr_s40];
		end
	end

	// Sine times amplitude (Q12.4), times rate, round to whole z units
	always_ff @(posedge clk) begin
		logic signed [15:0] sine;
		logic signed [49:0] pr;
		sine = neg_s[STG_ROM] ? -$signed({1'b0, mag_s41}) : $signed({1'b0, mag_s41});
		pr   = p_s43 + (50'sd1 <<< 34);
		if (en) begin
			sa_s42   <= sine * amplitude_q;
			p_s43    <= 50'(sa_s42) * 50'($signed({1'b0, rate_s[STG_SA]}));
			disp_s44 <= pr[49:35];
		end
	end

	// Add, saturate, present the result; outside the disc z passes through
	always_ff @(posedge clk) begin
		logic signed [16:0] sum;
		sum = 17'(vz_s[STG_DISP]) + 17'(disp_s44);
		if (en) begin
			inside_s45 <= inside_s[STG_DISP];
			if (!inside_s[STG_DISP]) begin
				new_z_s45 <= vz_s[STG_DISP];
			end else if (sum > 17'sd32767) begin
				new_z_s45 <= 16'sh7fff;
			end else if (sum < -17'sd32768) begin
				new_z_s45 <= 16'sh8000;
			end else begin
				new_z_s45 <= sum[15:0];
			end
		end
	end

`ifndef SYNTHESIS
	// A vertex inside the disc is strictly closer than the rim
	a_r_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[STG_R] && inside_s[STG_R] |-> r_s21 != '0)
		else $error("inside vertex with zero rim distance");

	// Falloff quotient never exceeds 1.0
	a_q_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[STG_DVL] && inside_s[STG_DVL] |-> div_q_s[STG_DVL] <= 17'd65536)
		else $error("falloff quotient above one");

	// A stall freezes the valid bits
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("valid bits moved during a stall");

	// Root never exceeds the radicand's square root bound
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[STG_SQL] |-> sqt_root_s[STG_SQL] <= 17'd92681)
		else $error("square root out of range");
`endif

endmodule
